/* sv/robin_hood_hash_multimap_defines.svh */
// assertion macros for the robin hood hash multimap
// used by the top level, needs clock and reset in scope
`ifndef ROBIN_HOOD_HASH_MULTIMAP_DEFINES_SVH
`define ROBIN_HOOD_HASH_MULTIMAP_DEFINES_SVH

// condition holds in the same cycle
`define RHM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define RHM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/rhm_pkg.sv */
// types, codes and the key mixer of the robin hood hash multimap
// no dependencies
`default_nettype none

package rhm_pkg;

   localparam logic [31:0] MIX_MULT = 32'h045d9f3b;
   localparam logic [6:0]  MAX_HITS = 7'd64;
   localparam logic [5:0]  FILL_RESET = 6'd48;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_ERASE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIX1,
      ST_MIX2,
      ST_HOME,
      ST_INS_RD,
      ST_INS_EV,
      ST_LK_RD,
      ST_LK_EV,
      ST_ER_RD,
      ST_ER_EV,
      ST_SH_RD,
      ST_SH_EV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic        used;
      logic [5:0]  probe_dist;
      logic [31:0] key;
      logic [31:0] value;
   } entry_type;

   function automatic logic [31:0] mix_step(input logic [31:0] x);
      logic [31:0] f;
      f = x ^ (x >> 16);
      return f * MIX_MULT;
   endfunction

endpackage

`default_nettype wire

/* sv/rhm_ram.sv */
// generic simple dual port ram, one write and one registered read a cycle
// no dependencies
`default_nettype none

module rhm_ram #(
   parameter int WIDTH = 71,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/robin_hood_hash_multimap.sv */
// robin hood open addressed multimap, top level
// uses rhm_pkg, rhm_ram and robin_hood_hash_multimap_defines.svh
//
//   channel   dir  handshake        payload
//   req       in   tvalid/tready    tuser op, tdata key/value
//   rsp       out  tvalid/tready    tuser status/hit, tdata value/total, tlast
//   csr       in   wr_en            wr_data max_fill
//
// an accepted word goes through key mixing (two multiplier passes and a fold),
// then a read and an evaluate state per probed slot on the single ram read port
// and a load of the rsp register; erase adds a read and an evaluate state per
// shifted entry and a re-read of each freed slot, and lookup results wait on rsp_tready
// after reset a clearing pass writes every slot with req_tready low
// a finished result sits in the rsp register while the next word is accepted
`default_nettype none

module robin_hood_hash_multimap #(
   parameter int SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // operation
   input  wire logic [63:0] req_tdata,   // key, value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // status, hit
   output logic [39:0]      rsp_tdata,   // found_value, entry_total, zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   import rhm_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int NW = IW + 1;
   localparam int EW = $bits(entry_type);

   state_type      state_ff, state_in;
   logic [5:0]     max_fill_ff, max_fill_in;
   logic [5:0]     cnt_ff, cnt_in;
   op_type         op_ff, op_in;
   logic [31:0]    key_ff, key_in;
   logic [31:0]    ck_ff, ck_in;
   logic [31:0]    cv_ff, cv_in;
   logic [5:0]     cd_ff, cd_in;
   logic [31:0]    mix_ff, mix_in;
   logic [IW-1:0]  addr_ff, addr_in;
   logic [IW-1:0]  p_ff, p_in;
   logic [IW-1:0]  hole_ff, hole_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [NW-1:0]  m_ff, m_in;
   logic [6:0]     k_ff, k_in;
   logic           held_ff, held_in;
   logic [31:0]    held_val_ff, held_val_in;
   logic           status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_status_ff, rsp_status_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic [31:0]    rsp_value_ff, rsp_value_in;
   logic [5:0]     rsp_total_ff, rsp_total_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   entry_type      wr_entry;
   logic [EW-1:0]  rd_data;
   entry_type      rd;

   logic [31:0]    fold;
   logic           out_free;
   logic           walk_end;
   logic           key_hit;
   logic           take_match;
   logic           lk_stall;
   logic           full;
   logic           shift_stop;
   logic           accept;
   logic           ins_place;
   logic           walk_eval;
   logic           resp_stall;

   rhm_ram #(
      .WIDTH(EW),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd         = entry_type'(rd_data);
   assign fold       = mix_ff ^ (mix_ff >> 16);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign walk_end   = (n_ff == NW'(SLOTS)) || !rd.used;
   assign key_hit    = rd.key == key_ff;
   assign take_match = key_hit && (k_ff < MAX_HITS);
   assign lk_stall   = take_match && held_ff && !out_free;
   assign full       = (cnt_ff >= max_fill_ff) || (32'(cnt_ff) >= SLOTS);
   assign shift_stop = (m_ff == NW'(SLOTS)) || !rd.used || (rd.probe_dist == 6'd0);
   assign accept     = req_tvalid && req_tready;
   assign ins_place  = (state_ff == ST_INS_EV) && walk_end;
   assign walk_eval  = state_ff inside {ST_INS_EV, ST_LK_EV, ST_ER_EV};
   assign resp_stall = (state_ff == ST_RESP) && rsp_valid_ff && !rsp_tready;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_hit_ff, rsp_status_ff};
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (n_ff[IW-1:0] == IW'(SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_MIX1;
         end
         ST_MIX1: state_in = ST_MIX2;
         ST_MIX2: state_in = ST_HOME;
         ST_HOME: begin
            case (op_ff)
               OP_INSERT: state_in = full ? ST_RESP : ST_INS_RD;
               OP_LOOKUP: state_in = ST_LK_RD;
               OP_ERASE:  state_in = ST_ER_RD;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_INS_RD: state_in = ST_INS_EV;
         ST_INS_EV: state_in = walk_end ? ST_RESP : ST_INS_RD;
         ST_LK_RD:  state_in = ST_LK_EV;
         ST_LK_EV: begin
            if (walk_end) state_in = ST_RESP;
            else if (!lk_stall) state_in = ST_LK_RD;
         end
         ST_ER_RD:  state_in = ST_ER_EV;
         ST_ER_EV: begin
            if (walk_end) state_in = ST_RESP;
            else if (key_hit) state_in = ST_SH_RD;
            else state_in = ST_ER_RD;
         end
         ST_SH_RD:  state_in = ST_SH_EV;
         ST_SH_EV:  state_in = shift_stop ? ST_ER_RD : ST_SH_RD;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      max_fill_in   = csr_wr_en ? csr_wr_data : max_fill_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      ck_in         = ck_ff;
      cv_in         = cv_ff;
      cd_in         = cd_ff;
      mix_in        = mix_ff;
      addr_in       = addr_ff;
      p_in          = p_ff;
      hole_in       = hole_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      k_in          = k_ff;
      held_in       = held_ff;
      held_val_in   = held_val_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_entry      = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = n_ff[IW-1:0];
            n_in    = n_ff + NW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = op_type'(req_tuser);
               key_in = req_tdata[31:0];
               ck_in  = req_tdata[31:0];
               cv_in  = req_tdata[63:32];
               mix_in = req_tdata[31:0];
            end
         end
         ST_MIX1, ST_MIX2: begin
            mix_in = mix_step(mix_ff);
         end
         ST_HOME: begin
            addr_in     = fold[IW-1:0];
            n_in        = '0;
            cd_in       = '0;
            k_in        = '0;
            held_in     = 1'b0;
            held_val_in = '0;
            status_in   = (op_ff == OP_INSERT) && full;
         end
         ST_INS_EV: begin
            if (walk_end) begin
               wr_en    = 1'b1;
               wr_entry = '{used: 1'b1, probe_dist: cd_ff, key: ck_ff, value: cv_ff};
               cnt_in   = cnt_ff + 6'd1;
            end else begin
               cd_in = cd_ff + 6'd1;
               if (cd_ff > rd.probe_dist) begin
                  wr_en    = 1'b1;
                  wr_entry = '{used: 1'b1, probe_dist: cd_ff, key: ck_ff, value: cv_ff};
                  ck_in    = rd.key;
                  cv_in    = rd.value;
                  cd_in    = rd.probe_dist + 6'd1;
               end
               addr_in = addr_ff + IW'(1);
               n_in    = n_ff + NW'(1);
            end
         end
         ST_LK_EV: begin
            if (!walk_end && !lk_stall) begin
               if (take_match) begin
                  if (held_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_hit_in    = 1'b1;
                     rsp_value_in  = held_val_ff;
                     rsp_total_in  = cnt_ff;
                     rsp_last_in   = 1'b0;
                  end
                  held_in     = 1'b1;
                  held_val_in = rd.value;
                  k_in        = k_ff + 7'd1;
               end
               addr_in = addr_ff + IW'(1);
               n_in    = n_ff + NW'(1);
            end
         end
         ST_ER_EV: begin
            if (!walk_end) begin
               if (key_hit) begin
                  p_in    = addr_ff;
                  hole_in = addr_ff;
                  m_in    = '0;
               end else begin
                  n_in = n_ff + NW'(1);
               end
               addr_in = addr_ff + IW'(1);
            end
         end
         ST_SH_EV: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            if (shift_stop) begin
               wr_entry = '0;
               if (cnt_ff != 6'd0) cnt_in = cnt_ff - 6'd1;
               addr_in  = p_ff;
            end else begin
               wr_entry = '{used: 1'b1, probe_dist: rd.probe_dist - 6'd1, key: rd.key,
                            value: rd.value};
               hole_in  = addr_ff;
               addr_in  = addr_ff + IW'(1);
               m_in     = m_ff + NW'(1);
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_hit_in    = held_ff;
               rsp_value_in  = held_val_ff;
               rsp_total_in  = cnt_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         max_fill_ff  <= FILL_RESET;
         cnt_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_fill_ff  <= max_fill_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      ck_ff         <= ck_in;
      cv_ff         <= cv_in;
      cd_ff         <= cd_in;
      mix_ff        <= mix_in;
      addr_ff       <= addr_in;
      p_ff          <= p_in;
      hole_ff       <= hole_in;
      m_ff          <= m_in;
      k_ff          <= k_in;
      held_ff       <= held_in;
      held_val_ff   <= held_val_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

`include "robin_hood_hash_multimap_defines.svh"

   `RHM_ASSERT_NEXT(a_ins_count, ins_place, cnt_ff == $past(cnt_ff) + 6'd1, "insert lost")
   `RHM_ASSERT_NOW(a_walk_bound, walk_eval, n_ff <= NW'(SLOTS), "probe walk ran past the table")
   `RHM_ASSERT_NEXT(a_resp_hold, resp_stall, (state_ff == ST_RESP) && rsp_valid_ff, "rsp lost")

endmodule

`default_nettype wire

/* test/rhm_checker.sv */
// checker for the robin hood hash multimap: watches req, rsp and csr, predicts
// every response word and compares it field by field; depends on rhm_pkg
module rhm_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [1:0]  req_tuser,
   input  wire logic [63:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rhm_pkg::*;

   localparam int NSLOT = 64;

   typedef struct packed {
      logic        status;
      logic        hit;
      logic [31:0] found;
      logic [5:0]  total;
      logic        last;
   } rsp_word_type;

   logic         tbl_used [NSLOT];
   logic [31:0]  tbl_key  [NSLOT];
   logic [31:0]  tbl_val  [NSLOT];
   logic [5:0]   tbl_dist [NSLOT];
   int           tbl_count;
   logic [5:0]   fill_limit;
   rsp_word_type expected_rsp[$];

   assign pending = expected_rsp.size();

   function automatic logic [31:0] hash_home(input logic [31:0] k);
      logic [31:0] x;
      x = ((k >> 16) ^ k) * 32'h045d9f3b;
      x = ((x >> 16) ^ x) * 32'h045d9f3b;
      return (x >> 16) ^ x;
   endfunction

   function automatic void push_rsp(input logic st, input logic h, input logic [31:0] v,
                                    input logic l);
      rsp_word_type w;
      w.status = st;
      w.hit = h;
      w.found = v;
      w.total = tbl_count[5:0];
      w.last = l;
      expected_rsp.push_back(w);
   endfunction

   function automatic void drop_slot(input int p);
      int hole, q;
      hole = p;
      q = (p + 1) % NSLOT;
      for (int n = 0; n < NSLOT; n++) begin
         if (!tbl_used[q] || tbl_dist[q] == 0) break;
         tbl_key[hole] = tbl_key[q];
         tbl_val[hole] = tbl_val[q];
         tbl_dist[hole] = tbl_dist[q] - 6'd1;
         hole = q;
         q = (q + 1) % NSLOT;
      end
      tbl_used[hole] = 1'b0;
      tbl_dist[hole] = '0;
      if (tbl_count > 0) tbl_count--;
   endfunction

   function automatic void apply_op(input op_type op, input logic [31:0] k,
                                    input logic [31:0] v);
      int p, n, hits;
      logic [31:0] ck, cv, tk, tv;
      logic [5:0] cd, td;
      p = hash_home(k) % NSLOT;
      hits = 0;
      case (op)
         OP_INSERT: begin
            if (tbl_count >= fill_limit || tbl_count >= NSLOT) begin
               push_rsp(1'b1, 1'b0, '0, 1'b1);
            end else begin
               ck = k; cv = v; cd = '0;
               for (n = 0; n < NSLOT && tbl_used[p]; n++) begin
                  if (cd > tbl_dist[p]) begin
                     tk = tbl_key[p]; tv = tbl_val[p]; td = tbl_dist[p];
                     tbl_key[p] = ck; tbl_val[p] = cv; tbl_dist[p] = cd;
                     ck = tk; cv = tv; cd = td;
                  end
                  cd = cd + 6'd1;
                  p = (p + 1) % NSLOT;
               end
               tbl_used[p] = 1'b1;
               tbl_key[p] = ck; tbl_val[p] = cv; tbl_dist[p] = cd;
               tbl_count++;
               push_rsp(1'b0, 1'b0, '0, 1'b1);
            end
         end
         OP_LOOKUP: begin
            for (n = 0; n < NSLOT && tbl_used[p]; n++) begin
               if (tbl_key[p] == k && hits < 64) begin
                  push_rsp(1'b0, 1'b1, tbl_val[p], 1'b0);
                  hits++;
               end
               p = (p + 1) % NSLOT;
            end
            if (hits == 0) push_rsp(1'b0, 1'b0, '0, 1'b1);
            else expected_rsp[$].last = 1'b1;
         end
         OP_ERASE: begin
            n = 0;
            while (n < NSLOT && tbl_used[p]) begin
               if (tbl_key[p] == k) drop_slot(p);
               else begin
                  p = (p + 1) % NSLOT;
                  n++;
               end
            end
            push_rsp(1'b0, 1'b0, '0, 1'b1);
         end
         default: push_rsp(1'b0, 1'b0, '0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_dist[i] = '0;
         end
         tbl_count = 0;
         fill_limit = FILL_RESET;
         fail_count <= 0;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) fill_limit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response word");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tuser[0] !== want.status ||
                   rsp_tuser[1] !== want.hit ||
                   rsp_tdata[31:0] !== want.found ||
                   rsp_tdata[37:32] !== want.total ||
                   rsp_tlast !== want.last) begin
                  if (rsp_tuser[0] !== want.status)
                     $error("status exp %0d got %0d", want.status, rsp_tuser[0]);
                  if (rsp_tuser[1] !== want.hit)
                     $error("hit exp %0d got %0d", want.hit, rsp_tuser[1]);
                  if (rsp_tdata[31:0] !== want.found)
                     $error("found_value exp %h got %h", want.found, rsp_tdata[31:0]);
                  if (rsp_tdata[37:32] !== want.total)
                     $error("entry_total exp %0d got %0d", want.total, rsp_tdata[37:32]);
                  if (rsp_tlast !== want.last)
                     $error("last exp %0d got %0d", want.last, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_op(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
      end
   end
endmodule

/* test/tb_top.sv */
// testbench top for robin_hood_hash_multimap: drives req and csr words with
// random idling, stalls rsp, and gives the verdict from rhm_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rhm_pkg::*;

   localparam int LIMIT = 2000000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [1:0]  req_tuser;
   logic [63:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [5:0]  csr_wr_data;
   int          fail_count, pending, cycle_count;
   int          send_idle, recv_idle;
   logic [31:0] key_pool[8];

   robin_hood_hash_multimap DUT (.*);
   rhm_checker chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   task automatic send_word(input op_type op, input logic [31:0] k, input logic [31:0] v);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {v, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic set_fill(input logic [5:0] f);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= f;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_run(input int count);
      int r;
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         k = (r < 85) ? key_pool[$urandom_range(7)] : $urandom;
         if (r < 45) send_word(OP_INSERT, k, $urandom);
         else if (r < 75) send_word(OP_LOOKUP, k, $urandom);
         else if (r < 95) send_word(OP_ERASE, k, $urandom);
         else send_word(OP_NONE, k, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      cycle_count = 0;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle = 24;
      recv_idle = 63;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hffffffff;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_word(OP_LOOKUP, 32'h0, 32'h0);
      send_word(OP_ERASE, 32'hffffffff, 32'h0);
      send_word(OP_INSERT, 32'h0, 32'hffffffff);
      send_word(OP_INSERT, 32'h0, 32'h0);
      send_word(OP_INSERT, 32'hffffffff, 32'h12345678);
      send_word(OP_INSERT, 32'h0, 32'ha5a5a5a5);
      send_word(OP_LOOKUP, 32'h0, 32'h0);
      send_word(OP_NONE, 32'hffffffff, 32'hffffffff);
      send_word(OP_ERASE, 32'h0, 32'h0);
      send_word(OP_LOOKUP, 32'h0, 32'h0);
      send_word(OP_LOOKUP, 32'hffffffff, 32'h0);
      set_fill(6'd1);
      send_word(OP_INSERT, 32'h5a5a5a5a, 32'h1);
      send_word(OP_INSERT, 32'h0, 32'h2);
      set_fill(6'd63);
      for (int i = 0; i < 66; i++) send_word(OP_INSERT, key_pool[i % 3], i);
      send_word(OP_LOOKUP, key_pool[2], 32'h0);
      send_word(OP_LOOKUP, key_pool[0], 32'h0);
      drain();
      for (int i = 0; i < 3; i++) send_word(OP_ERASE, key_pool[i], 32'h0);
      set_fill(6'd0);
      send_word(OP_INSERT, 32'h1, 32'h1);
      set_fill(6'd12);

      random_run(12);
      send_idle = 63;
      recv_idle = 24;
      drain();
      set_fill(6'd48);
      random_run(12);
      send_idle = 0;
      recv_idle = 0;
      random_run(12);
      drain();
      if (fail_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule

/* robin_hood_hash_multimap.f */
+incdir+sv
sv/rhm_pkg.sv
sv/rhm_ram.sv
sv/robin_hood_hash_multimap.sv
test/rhm_checker.sv
test/tb_top.sv
